// ----- hdl/gcmf_pkg.sv -----
// Shared constants, types and helper functions of the gray cross-mean filter.
`default_nettype none

package gcmf_pkg;

	// Default sizes handed to the top level parameters.
	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_MAX_HEIGHT  = 4096;
	localparam int DEF_QUEUE_DEPTH = 4;

	// Field and register widths fixed by the interface.
	localparam int PIX_W         = 8;
	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_INDEX_W    = 1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

	// Register values after reset.
	localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	// Luma weights in thousandths; the weighted sum stays below 2^18.
	localparam int WSUM_W = 18;
	localparam logic [WSUM_W-1:0] GRAY_WR = 18'd299;
	localparam logic [WSUM_W-1:0] GRAY_WG = 18'd587;
	localparam logic [WSUM_W-1:0] GRAY_WB = 18'd114;

	// Division by 1000 as a multiply by ceil(2^28 / 1000) and a shift.
	localparam int GRAY_RECIP_W = 19;
	localparam logic [GRAY_RECIP_W-1:0] GRAY_RECIP = 19'd268436;
	localparam int GRAY_SHIFT = 28;

	// Neighbour sum (up to five bytes) and neighbour count (1 to 5).
	localparam int SUM_W = 11;
	localparam int CNT_W = 3;

	// Division by the count as a multiply by a scaled reciprocal and a shift.
	localparam int DIV_FACTOR_W = 14;
	localparam int DIV_SHIFT    = 13;

	typedef enum logic {
		JOB_PIXEL,
		JOB_DRAIN
	} job_kind_t;

	// Control part of one job passed from the front to the back.
	typedef struct packed {
		job_kind_t kind;
		logic      emit;
		logic      has_up;
		logic      has_left;
		logic      has_right;
		logic      frame_end;
	} job_ctrl_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RD_CENTRE,
		BK_RD_LEFT,
		BK_RD_RIGHT,
		BK_SUM,
		BK_DIV
	} back_state_t;

	// Scaled reciprocal of the neighbour count: floor(x / n) = (x * f) >> 13
	// holds for every sum up to 1275.
	function automatic logic [DIV_FACTOR_W-1:0] div_factor(input logic [CNT_W-1:0] cnt);
		logic [DIV_FACTOR_W-1:0] f;
		unique case (cnt)
			3'd1:    f = 14'd8192;
			3'd2:    f = 14'd4096;
			3'd3:    f = 14'd2731;
			3'd4:    f = 14'd2048;
			3'd5:    f = 14'd1639;
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/gcmf_pixel_if.sv -----
// Input channel carrying pixel items and drain commands.
`default_nettype none

interface gcmf_pixel_if;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [gcmf_pkg::PIX_W-1:0] red;
	logic [gcmf_pkg::PIX_W-1:0] green;
	logic [gcmf_pkg::PIX_W-1:0] blue;

	modport source (output valid, command, red, green, blue, input ready);
	modport sink   (input valid, command, red, green, blue, output ready);
endinterface

`default_nettype wire

// ----- hdl/gcmf_result_if.sv -----
// Output channel carrying filtered gray pixels.
`default_nettype none

interface gcmf_result_if;
	logic                      valid;
	logic                      ready;
	logic [gcmf_pkg::PIX_W-1:0] mean_gray;
	logic                      frame_end;

	modport source (output valid, mean_gray, frame_end, input ready);
	modport sink   (input valid, mean_gray, frame_end, output ready);
endinterface

`default_nettype wire

// ----- hdl/gcmf_front.sv -----
// Front end: accepts items, tracks frame positions and converts RGB to gray.
`default_nettype none

module gcmf_front #(
	parameter int MAX_WIDTH  = gcmf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gcmf_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	gcmf_pixel_if.sink                        pixels,
	input  logic                              cfg_write,
	input  logic [gcmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [gcmf_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              job_valid,
	input  logic                              job_ready,
	output gcmf_pkg::job_ctrl_t               job_ctrl,
	output logic [$clog2(MAX_WIDTH)-1:0]      job_col,
	output logic [gcmf_pkg::PIX_W-1:0]        job_gray
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = gcmf_pkg::WSUM_W + gcmf_pkg::GRAY_RECIP_W;

	logic [gcmf_pkg::FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [gcmf_pkg::FRAME_HEIGHT_W-1:0] frame_height_q;
	logic [HW-1:0] in_row_q;
	logic [CW-1:0] in_col_q;
	logic [CW-1:0] out_col_q;
	logic          drain_pending_q;
	logic          drain_up_q;

	logic          valid_s1;
	gcmf_pkg::job_ctrl_t ctrl_s1;
	logic [CW-1:0] col_s1;
	logic [gcmf_pkg::WSUM_W-1:0] wsum_s1;
	logic          valid_s2;
	gcmf_pkg::job_ctrl_t ctrl_s2;
	logic [CW-1:0] col_s2;
	logic [gcmf_pkg::PIX_W-1:0] gray_s2;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic          adv;
	logic          accept;
	logic          is_drain;
	logic          pos_wrap;
	logic [HW-1:0] r;
	logic [CW-1:0] c;
	logic [WW-1:0] c_next;
	logic [HW-1:0] r_next;
	logic          last_col;
	logic          last_row;
	logic [WW-1:0] d_next;
	logic          drain_live;
	logic          drain_last;
	gcmf_pkg::job_ctrl_t pix_ctrl;
	gcmf_pkg::job_ctrl_t drn_ctrl;
	logic [gcmf_pkg::WSUM_W-1:0] wsum;
	logic [PW-1:0] gray_prod;

	// Registers clamped to the supported frame size.
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(frame_height_q);
		end
	end

	// The front moves whenever its last stage is empty or hands off a job.
	assign adv          = !valid_s2 || job_ready;
	assign pixels.ready = adv;
	assign accept       = pixels.valid && adv;
	assign is_drain     = pixels.command;

	// Position of the incoming pixel and where the raster goes next.
	always_comb begin
		pos_wrap = (WW'(in_col_q) >= w_eff) || (in_row_q >= h_eff);
		r        = pos_wrap ? '0 : in_row_q;
		c        = pos_wrap ? '0 : in_col_q;
		c_next   = WW'(c) + WW'(1);
		r_next   = r + HW'(1);
		last_col = c_next >= w_eff;
		last_row = r_next >= h_eff;

		pix_ctrl.kind      = gcmf_pkg::JOB_PIXEL;
		pix_ctrl.emit      = r != '0;
		pix_ctrl.has_up    = r > HW'(1);
		pix_ctrl.has_left  = c != '0;
		pix_ctrl.has_right = !last_col;
		pix_ctrl.frame_end = 1'b0;
	end

	// A drain flushes one pixel of the pending last row.
	always_comb begin
		d_next     = WW'(out_col_q) + WW'(1);
		drain_live = drain_pending_q && (WW'(out_col_q) < w_eff);
		drain_last = d_next == w_eff;

		drn_ctrl.kind      = gcmf_pkg::JOB_DRAIN;
		drn_ctrl.emit      = 1'b1;
		drn_ctrl.has_up    = drain_up_q;
		drn_ctrl.has_left  = out_col_q != '0;
		drn_ctrl.has_right = d_next < w_eff;
		drn_ctrl.frame_end = drain_last;
	end

	// Weighted sum of the colour bytes.
	assign wsum = gcmf_pkg::GRAY_WR * gcmf_pkg::WSUM_W'(pixels.red)
		+ gcmf_pkg::GRAY_WG * gcmf_pkg::WSUM_W'(pixels.green)
		+ gcmf_pkg::GRAY_WB * gcmf_pkg::WSUM_W'(pixels.blue);

	assign gray_prod = PW'(wsum_s1) * PW'(gcmf_pkg::GRAY_RECIP);

	// Configuration registers and frame position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= gcmf_pkg::FRAME_WIDTH_RST;
			frame_height_q  <= gcmf_pkg::FRAME_HEIGHT_RST;
			in_row_q        <= '0;
			in_col_q        <= '0;
			out_col_q       <= '0;
			drain_pending_q <= 1'b0;
			drain_up_q      <= 1'b0;
		end else if (cfg_write) begin
			if (cfg_index == gcmf_pkg::CFG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data[gcmf_pkg::FRAME_WIDTH_W-1:0];
			end else if (cfg_index == gcmf_pkg::CFG_FRAME_HEIGHT) begin
				frame_height_q <= cfg_data[gcmf_pkg::FRAME_HEIGHT_W-1:0];
			end
			in_row_q        <= '0;
			in_col_q        <= '0;
			out_col_q       <= '0;
			drain_pending_q <= 1'b0;
		end else if (accept && is_drain) begin
			if (!drain_live || drain_last) begin
				drain_pending_q <= 1'b0;
				out_col_q       <= '0;
			end else begin
				out_col_q <= CW'(d_next);
			end
		end else if (accept) begin
			drain_pending_q <= last_col && last_row;
			if (last_col) begin
				in_col_q <= '0;
				in_row_q <= last_row ? '0 : r_next;
				if (last_row) begin
					drain_up_q <= h_eff > HW'(1);
					out_col_q  <= '0;
				end
			end else begin
				in_col_q <= CW'(c_next);
				in_row_q <= r;
			end
		end
	end

	// Valid bits of the two front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept && (!is_drain || drain_live);
			valid_s2 <= valid_s1;
		end
	end

	// Stage payloads: weighted sum first, gray value after the reciprocal multiply.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s1 <= is_drain ? drn_ctrl : pix_ctrl;
			col_s1  <= is_drain ? out_col_q : c;
			wsum_s1 <= wsum;
			ctrl_s2 <= ctrl_s1;
			col_s2  <= col_s1;
			gray_s2 <= gray_prod[gcmf_pkg::GRAY_SHIFT +: gcmf_pkg::PIX_W];
		end
	end

	assign job_valid = valid_s2;
	assign job_ctrl  = ctrl_s2;
	assign job_col   = col_s2;
	assign job_gray  = gray_s2;

endmodule

`default_nettype wire

// ----- hdl/gcmf_queue.sv -----
// Short job queue between the front end and the back end.
`default_nettype none

module gcmf_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = gcmf_pkg::DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	// Pointers wrap at the queue depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/gcmf_back.sv -----
// Back end: line stores, neighbour gathering, mean and the result register.
`default_nettype none

module gcmf_back #(
	parameter int MAX_WIDTH = gcmf_pkg::DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	output logic                         job_ready,
	input  gcmf_pkg::job_ctrl_t          job_ctrl,
	input  logic [$clog2(MAX_WIDTH)-1:0] job_col,
	input  logic [gcmf_pkg::PIX_W-1:0]   job_gray,
	gcmf_result_if.source                results
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = gcmf_pkg::SUM_W;
	localparam int NW = gcmf_pkg::CNT_W;
	localparam int PW = gcmf_pkg::SUM_W + gcmf_pkg::DIV_FACTOR_W;

	gcmf_pkg::back_state_t state_q;
	gcmf_pkg::back_state_t state_d;

	logic [gcmf_pkg::PIX_W-1:0] upper_mem  [MAX_WIDTH];
	logic [gcmf_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [gcmf_pkg::PIX_W-1:0] mid_rdata_q;
	logic [gcmf_pkg::PIX_W-1:0] up_rdata_q;
	logic [CW-1:0]              mid_raddr;
	logic [CW-1:0]              up_raddr;
	logic                       mem_we;

	gcmf_pkg::job_ctrl_t        ctrl_q;
	logic [CW-1:0]              col_q;
	logic [gcmf_pkg::PIX_W-1:0] gray_q;
	logic [gcmf_pkg::PIX_W-1:0] centre_q;
	logic [gcmf_pkg::PIX_W-1:0] up_q;
	logic [gcmf_pkg::PIX_W-1:0] left_q;
	logic [gcmf_pkg::PIX_W-1:0] left_centre_q;
	logic [SW-1:0]              sum_q;
	logic [NW-1:0]              cnt_q;
	logic                       out_valid_q;
	logic [gcmf_pkg::PIX_W-1:0] mean_q;
	logic                       end_q;

	logic                       is_pixel;
	logic                       out_load;
	logic [gcmf_pkg::PIX_W-1:0] left_val;
	logic [SW-1:0]              sum_d;
	logic [NW-1:0]              cnt_d;
	logic [PW-1:0]              div_prod;

	assign is_pixel = ctrl_q.kind == gcmf_pkg::JOB_PIXEL;

	// Next state of the job sequencer.
	always_comb begin
		unique case (state_q)
			gcmf_pkg::BK_IDLE:      state_d = job_valid ? gcmf_pkg::BK_RD_CENTRE : gcmf_pkg::BK_IDLE;
			gcmf_pkg::BK_RD_CENTRE: state_d = gcmf_pkg::BK_RD_LEFT;
			gcmf_pkg::BK_RD_LEFT:   state_d = gcmf_pkg::BK_RD_RIGHT;
			gcmf_pkg::BK_RD_RIGHT:  state_d = gcmf_pkg::BK_SUM;
			gcmf_pkg::BK_SUM:       state_d = ctrl_q.emit ? gcmf_pkg::BK_DIV : gcmf_pkg::BK_IDLE;
			gcmf_pkg::BK_DIV:       state_d = out_load ? gcmf_pkg::BK_IDLE : gcmf_pkg::BK_DIV;
			default:                state_d = gcmf_pkg::BK_IDLE;
		endcase
	end

	// Sequencer outputs: read addresses, store write and result load.
	always_comb begin
		job_ready = state_q == gcmf_pkg::BK_IDLE;
		up_raddr  = col_q;
		unique case (state_q)
			gcmf_pkg::BK_RD_LEFT:  mid_raddr = col_q - CW'(1);
			gcmf_pkg::BK_RD_RIGHT: mid_raddr = col_q + CW'(1);
			default:               mid_raddr = col_q;
		endcase
		mem_we   = (state_q == gcmf_pkg::BK_SUM) && is_pixel;
		out_load = (state_q == gcmf_pkg::BK_DIV) && (!out_valid_q || results.ready);
	end

	// Neighbour sum and count; the right neighbour is on the read port now.
	always_comb begin
		left_val = is_pixel ? left_centre_q : left_q;
		sum_d    = SW'(centre_q);
		cnt_d    = NW'(1);
		if (is_pixel) begin
			sum_d = sum_d + SW'(gray_q);
			cnt_d = cnt_d + NW'(1);
		end
		if (ctrl_q.has_up) begin
			sum_d = sum_d + SW'(up_q);
			cnt_d = cnt_d + NW'(1);
		end
		if (ctrl_q.has_left) begin
			sum_d = sum_d + SW'(left_val);
			cnt_d = cnt_d + NW'(1);
		end
		if (ctrl_q.has_right) begin
			sum_d = sum_d + SW'(mid_rdata_q);
			cnt_d = cnt_d + NW'(1);
		end
	end

	assign div_prod = PW'(sum_q) * PW'(gcmf_pkg::div_factor(cnt_q));

	// Line stores with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			upper_mem[col_q]  <= centre_q;
			middle_mem[col_q] <= gray_q;
		end
		mid_rdata_q <= middle_mem[mid_raddr];
		up_rdata_q  <= upper_mem[up_raddr];
	end

	// Control state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gcmf_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Job fields, gathered neighbours, sum and result data.
	always_ff @(posedge clk) begin
		if (state_q == gcmf_pkg::BK_IDLE && job_valid) begin
			ctrl_q <= job_ctrl;
			col_q  <= job_col;
			gray_q <= job_gray;
		end
		if (state_q == gcmf_pkg::BK_RD_LEFT) begin
			centre_q <= mid_rdata_q;
			up_q     <= up_rdata_q;
		end
		if (state_q == gcmf_pkg::BK_RD_RIGHT) begin
			left_q <= mid_rdata_q;
		end
		if (state_q == gcmf_pkg::BK_SUM) begin
			sum_q <= sum_d;
			cnt_q <= cnt_d;
		end
		if (mem_we) begin
			left_centre_q <= centre_q;
		end
		if (out_load) begin
			mean_q <= div_prod[gcmf_pkg::DIV_SHIFT +: gcmf_pkg::PIX_W];
			end_q  <= ctrl_q.frame_end;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.mean_gray = mean_q;
	assign results.frame_end = end_q;

	// A mean is only taken over one to five neighbours.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gcmf_pkg::BK_DIV |-> (cnt_q >= NW'(1)) && (cnt_q <= NW'(5)))
		else $error("neighbour count out of range");

	// The sum never exceeds a full byte per counted neighbour.
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gcmf_pkg::BK_DIV |-> sum_q <= SW'(255) * SW'(cnt_q))
		else $error("neighbour sum exceeds count bound");

	// A left neighbour exists exactly off the first column.
	a_left_col: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != gcmf_pkg::BK_IDLE |-> ctrl_q.has_left == (col_q != '0))
		else $error("left neighbour flag disagrees with column");

	// Drains never reach the line stores and always produce a result.
	a_drain_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gcmf_pkg::BK_SUM) && !is_pixel |-> ctrl_q.emit && !mem_we)
		else $error("drain job without result or with a store write");

endmodule

`default_nettype wire

// ----- hdl/gray_cross_mean_filter.sv -----
// Top level of the gray cross-mean filter.
//
//   Channel    Direction  Payload                        Transfer when
//   pixels     in         command, red, green, blue      valid && ready
//   results    out        mean_gray, frame_end           valid && ready
//   cfg_*      in         cfg_index, cfg_data            cfg_write
//
// The front end takes an item each cycle while its queue has room; gray is
// registered after the weighted sum and the reciprocal multiply. The back end
// reads centre, left and right in turn through the single read port of the
// middle line store, sums the cross and divides for a result or a drain.
// A drain with nothing pending is dropped in the front end.
// Reset clears control state only; line stores are not cleared.
// A waiting result does not stop the back end until the next result is due.
`default_nettype none

module gray_cross_mean_filter #(
	parameter int MAX_WIDTH   = gcmf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = gcmf_pkg::DEF_MAX_HEIGHT,
	parameter int QUEUE_DEPTH = gcmf_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	gcmf_pixel_if.sink                       pixels,
	gcmf_result_if.source                    results,
	input  logic                             cfg_write,
	input  logic [gcmf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gcmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int CTRL_W = $bits(gcmf_pkg::job_ctrl_t);
	localparam int QW     = CTRL_W + CW + gcmf_pkg::PIX_W;

	logic                       f_valid;
	logic                       f_ready;
	gcmf_pkg::job_ctrl_t        f_ctrl;
	logic [CW-1:0]              f_col;
	logic [gcmf_pkg::PIX_W-1:0] f_gray;
	logic                       b_valid;
	logic                       b_ready;
	gcmf_pkg::job_ctrl_t        b_ctrl;
	logic [CW-1:0]              b_col;
	logic [gcmf_pkg::PIX_W-1:0] b_gray;
	logic [QW-1:0]              q_in;
	logic [QW-1:0]              q_out;

	// Item intake, position tracking and gray conversion.
	gcmf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job_ctrl  (f_ctrl),
		.job_col   (f_col),
		.job_gray  (f_gray)
	);

	assign q_in = {f_ctrl, f_col, f_gray};

	// Decoupling queue between the two ends.
	gcmf_queue #(
		.DATA_W (QW),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (q_in),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (q_out)
	);

	assign {b_ctrl, b_col, b_gray} = q_out;

	// Line stores and the cross mean.
	gcmf_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job_ctrl  (b_ctrl),
		.job_col   (b_col),
		.job_gray  (b_gray),
		.results   (results)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench of the gray cross-mean filter with a luma and neighbor-mean predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

	localparam int MAX_W = gcmf_pkg::DEF_MAX_WIDTH;
	localparam int MAX_H = gcmf_pkg::DEF_MAX_HEIGHT;
	localparam int CLK_HALF_NS = 6;
	localparam int RESET_CYCLES = 6;
	// Margin for the front end, four queue slots and the back end to go quiet.
	localparam int SETTLE_CYCLES = 100;
	localparam int TIMEOUT_NS = 5_000_000;
	localparam int REPORT_LIMIT = 10;
	// Luma weights in thousandths.
	localparam int unsigned LUMA_R = 299;
	localparam int unsigned LUMA_G = 587;
	localparam int unsigned LUMA_B = 114;

	typedef struct packed {
		gcmf_pkg::job_kind_t           kind;
		logic [gcmf_pkg::PIX_W-1:0]    red;
		logic [gcmf_pkg::PIX_W-1:0]    green;
		logic [gcmf_pkg::PIX_W-1:0]    blue;
	} pixel_item_t;

	typedef struct packed {
		logic [gcmf_pkg::PIX_W-1:0] mean;
		logic                       frame_end;
	} mean_result_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_write;
	logic [gcmf_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [gcmf_pkg::CFG_DATA_W-1:0]  cfg_data;

	gcmf_pixel_if  pix_ch ();
	gcmf_result_if res_ch ();

	gray_cross_mean_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pix_ch),
		.results   (res_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Items waiting to be sent and filtered pixels still to arrive.
	pixel_item_t  pixel_backlog[$];
	mean_result_t pending_means[$];

	int unsigned send_idle_pct = 37;
	int unsigned stall_pct = 37;
	int unsigned fail_count = 0;
	int unsigned result_count = 0;
	int unsigned stim_pos;

	// Predictor copy of the registers, line stores and positions.
	logic [gcmf_pkg::FRAME_WIDTH_W-1:0]  width_reg;
	logic [gcmf_pkg::FRAME_HEIGHT_W-1:0] height_reg;
	logic [gcmf_pkg::PIX_W-1:0]          up_luma [MAX_W];
	logic [gcmf_pkg::PIX_W-1:0]          mid_luma [MAX_W];
	int unsigned               row_in, col_in, row_out, col_out, prev_centre;
	bit                        flush_due;

	function automatic int unsigned active_width();
		if (width_reg == '0)
			return 1;
		if (32'(width_reg) > MAX_W)
			return MAX_W;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned active_height();
		if (height_reg == '0)
			return 1;
		if (32'(height_reg) > MAX_H)
			return MAX_H;
		return 32'(height_reg);
	endfunction

	function automatic void restart_frame();
		row_in = 0;
		col_in = 0;
		row_out = 0;
		col_out = 0;
		prev_centre = 0;
		flush_due = 1'b0;
	endfunction

	// Advances the filter by one accepted item and queues the mean it produces, if any.
	function automatic void advance_filter(pixel_item_t item);
		int unsigned w, h, r, c, luma, centre, total, cnt;
		mean_result_t res;
		w = active_width();
		h = active_height();
		if (item.kind == gcmf_pkg::JOB_DRAIN) begin
			c = col_out;
			if (!flush_due || c >= w) begin
				flush_due = 1'b0;
				return;
			end
			total = 32'(mid_luma[c]);
			cnt = 1;
			if (row_out >= 1) begin
				total += 32'(up_luma[c]);
				cnt++;
			end
			if (c > 0) begin
				total += 32'(mid_luma[c - 1]);
				cnt++;
			end
			if (c + 1 < w) begin
				total += 32'(mid_luma[c + 1]);
				cnt++;
			end
			res.mean = gcmf_pkg::PIX_W'(total / cnt);
			res.frame_end = (c + 1 == w);
			pending_means.push_back(res);
			if (c + 1 == w) begin
				flush_due = 1'b0;
				col_out = 0;
			end else begin
				col_out = c + 1;
			end
			return;
		end

		luma = (LUMA_R * 32'(item.red) + LUMA_G * 32'(item.green)
			+ LUMA_B * 32'(item.blue)) / 1000;
		if (col_in >= w || row_in >= h) begin
			row_in = 0;
			col_in = 0;
		end
		// A pixel abandons any row still waiting to be flushed.
		flush_due = 1'b0;
		r = row_in;
		c = col_in;
		centre = 32'(mid_luma[c]);

		// The pixel below completes the mean of the one above it.
		if (r >= 1) begin
			total = centre + luma;
			cnt = 2;
			if (r >= 2) begin
				total += 32'(up_luma[c]);
				cnt++;
			end
			if (c > 0) begin
				total += prev_centre;
				cnt++;
			end
			if (c + 1 < w) begin
				total += 32'(mid_luma[c + 1]);
				cnt++;
			end
			res.mean = gcmf_pkg::PIX_W'(total / cnt);
			res.frame_end = 1'b0;
			pending_means.push_back(res);
		end

		prev_centre = centre;
		up_luma[c] = gcmf_pkg::PIX_W'(centre);
		mid_luma[c] = gcmf_pkg::PIX_W'(luma);

		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) begin
				r = 0;
				flush_due = 1'b1;
				row_out = h - 1;
				col_out = 0;
			end
		end
		row_in = r;
		col_in = c;
	endfunction

	function automatic void log_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	function automatic logic [gcmf_pkg::PIX_W-1:0] rand_byte();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return gcmf_pkg::PIX_W'($urandom_range(255));
	endfunction

	function automatic void add_pixel(logic [gcmf_pkg::PIX_W-1:0] r,
			logic [gcmf_pkg::PIX_W-1:0] g, logic [gcmf_pkg::PIX_W-1:0] b);
		pixel_item_t item;
		item.kind = gcmf_pkg::JOB_PIXEL;
		item.red = r;
		item.green = g;
		item.blue = b;
		pixel_backlog.push_back(item);
	endfunction

	// Drain ticks carry random pixel bytes, which the block must ignore.
	function automatic void add_drain();
		pixel_item_t item;
		item.kind = gcmf_pkg::JOB_DRAIN;
		item.red = rand_byte();
		item.green = rand_byte();
		item.blue = rand_byte();
		pixel_backlog.push_back(item);
	endfunction

	// Mostly whole frames followed by their drains, with stray and short drain runs.
	function automatic void queue_stream(int unsigned n);
		int unsigned w, h, k, pushed;
		w = active_width();
		h = active_height();
		pushed = 0;
		while (pushed < n) begin
			if ($urandom_range(99) < 6) begin
				add_drain();
			end else begin
				add_pixel(rand_byte(), rand_byte(), rand_byte());
				pushed++;
				stim_pos++;
				if (stim_pos == w * h) begin
					stim_pos = 0;
					if ($urandom_range(99) < 80)
						k = w + $urandom_range(1);
					else
						k = $urandom_range(w - 1);
					repeat (k) add_drain();
					pushed += k;
				end
			end
		end
	endfunction

	// Waits until every item is sent, every mean has come and the back end is quiet.
	task automatic wait_drained();
		@(posedge clk);
		while (pixel_backlog.size() != 0 || pix_ch.valid)
			@(posedge clk);
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gcmf_pkg::CFG_INDEX_W-1:0] idx,
			input logic [gcmf_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			gcmf_pkg::CFG_FRAME_WIDTH:
				width_reg = value[gcmf_pkg::FRAME_WIDTH_W-1:0];
			gcmf_pkg::CFG_FRAME_HEIGHT:
				height_reg = value[gcmf_pkg::FRAME_HEIGHT_W-1:0];
			default: ;
		endcase
		restart_frame();
	endtask

	task automatic run_phase(input logic [gcmf_pkg::CFG_DATA_W-1:0] w_data,
			input logic [gcmf_pkg::CFG_DATA_W-1:0] h_data, input int unsigned n,
			input int unsigned idle, input bit pause_mid);
		write_reg(gcmf_pkg::CFG_FRAME_WIDTH, w_data);
		write_reg(gcmf_pkg::CFG_FRAME_HEIGHT, h_data);
		send_idle_pct <= idle;
		stall_pct <= idle;
		stim_pos = 0;
		if (pause_mid) begin
			// The sender holds off until every outstanding mean has come.
			queue_stream(n / 2);
			wait_drained();
			queue_stream(n - n / 2);
		end else begin
			queue_stream(n);
		end
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	// Sends items from the backlog; each transfer updates the predictor.
	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_item_t nxt;
		pixel_item_t sent;
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
			pix_ch.command <= gcmf_pkg::JOB_PIXEL;
			pix_ch.red <= '0;
			pix_ch.green <= '0;
			pix_ch.blue <= '0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				sent.kind = gcmf_pkg::job_kind_t'(pix_ch.command);
				sent.red = pix_ch.red;
				sent.green = pix_ch.green;
				sent.blue = pix_ch.blue;
				advance_filter(sent);
			end
			if (!pix_ch.valid || pix_ch.ready) begin
				if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pixel_backlog.pop_front();
					pix_ch.valid <= 1'b1;
					pix_ch.command <= nxt.kind;
					pix_ch.red <= nxt.red;
					pix_ch.green <= nxt.green;
					pix_ch.blue <= nxt.blue;
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Stalls the result channel at random and checks every result transfer.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		mean_result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
			if (res_ch.valid && res_ch.ready) begin
				result_count++;
				if (pending_means.size() == 0) begin
					log_failure($sformatf("result %0d unexpected: mean %0d end %0b",
						result_count, res_ch.mean_gray, res_ch.frame_end));
				end else begin
					want = pending_means.pop_front();
					if (res_ch.mean_gray !== want.mean || res_ch.frame_end !== want.frame_end)
						log_failure($sformatf(
							"result %0d: expected mean %0d end %0b, got mean %0d end %0b",
							result_count, want.mean, want.frame_end,
							res_ch.mean_gray, res_ch.frame_end));
				end
			end
		end
	end

	// Main sequence: directed frames first, then random phases over several sizes.
	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = gcmf_pkg::CFG_FRAME_WIDTH;
		cfg_data = '0;
		width_reg = gcmf_pkg::FRAME_WIDTH_RST;
		height_reg = gcmf_pkg::FRAME_HEIGHT_RST;
		restart_frame();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// A drain with nothing pending, then two pixels at the reset frame size.
		add_drain();
		add_pixel(8'd10, 8'd20, 8'd30);
		add_pixel(8'd200, 8'd100, 8'd50);
		wait_drained();

		// A 3 x 2 frame with extreme colors, flushed by drains plus one extra.
		write_reg(gcmf_pkg::CFG_FRAME_WIDTH, 13'd3);
		write_reg(gcmf_pkg::CFG_FRAME_HEIGHT, 13'd2);
		add_pixel(8'd0, 8'd0, 8'd0);
		add_pixel(8'd255, 8'd255, 8'd255);
		add_pixel(8'd255, 8'd0, 8'd0);
		add_pixel(8'd0, 8'd255, 8'd0);
		add_pixel(8'd0, 8'd0, 8'd255);
		add_pixel(8'd1, 8'd1, 8'd1);
		repeat (4) add_drain();
		// A second frame whose flush is cut short by a new pixel.
		add_pixel(8'd128, 8'd64, 8'd32);
		add_pixel(8'd7, 8'd250, 8'd3);
		add_pixel(8'd255, 8'd255, 8'd0);
		add_pixel(8'd0, 8'd255, 8'd255);
		add_pixel(8'd85, 8'd170, 8'd85);
		add_pixel(8'd254, 8'd1, 8'd254);
		add_drain();
		add_pixel(8'd99, 8'd99, 8'd99);
		wait_drained();

		// Random phases: clamped and extreme sizes, small frames, no-idle and pause runs.
		run_phase(13'h0000, 13'h0001, 120, 37, 1'b0);
		run_phase(13'h1FFF, 13'h1FFF, 40, 37, 1'b0);
		run_phase(13'h0400, 13'h1000, 30, 37, 1'b0);
		run_phase(13'h0805, 13'd3, 250, 37, 1'b0);
		run_phase(13'd16, 13'd8, 350, 0, 1'b0);
		run_phase(13'd9, 13'd6, 400, 37, 1'b1);
		run_phase(13'd1, 13'd7, 150, 37, 1'b0);
		run_phase(13'd2, 13'h0000, 150, 37, 1'b0);
		run_phase(13'd7, 13'd4, 300, 37, 1'b0);
		run_phase(13'd4, 13'd4, 160, 37, 1'b0);

		if (fail_count == 0 && pending_means.size() == 0)
			$display("PASS gray_cross_mean_filter");
		else
			$display("FAIL gray_cross_mean_filter");
		$finish;
	end

	// Guards against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL gray_cross_mean_filter");
		$finish;
	end

endmodule

`default_nettype wire
